/* rtl/core/pdll_pkg.sv */
package pdll_pkg;

  localparam int unsigned DefaultCapacity = 32;

  localparam logic [2:0] FuncInsert  = 3'd0;
  localparam logic [2:0] FuncDelete  = 3'd1;
  localparam logic [2:0] FuncSearch  = 3'd2;
  localparam logic [2:0] FuncReadFwd = 3'd3;
  localparam logic [2:0] FuncReadRev = 3'd4;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StRange    = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StEmpty    = 3'd3;
  localparam logic [2:0] StNotFound = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture the request and pick the start node
    logic       start_rev; // walk starts at the tail
    logic       rd;        // issue a read of the current node
    logic       step_fwd;  // move to the next node
    logic       step_rev;  // move to the previous node
    logic       link_ins;  // write the new node's links and value
    logic       link_del;  // unlink the current node
    logic       stash;     // park the current search hit
    logic       emit;      // load the output register
    logic [2:0] emit_st;
    logic       emit_elem; // use the element value and walk position
    logic       emit_held; // use the parked search hit
    logic       emit_last;
  } pdll_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       match;     // current node value equals the search value
    logic       walk_done; // walk position reached the target
    logic       out_busy;  // output register still holds a result
  } pdll_sts_t;

endpackage

/* rtl/core/pdll_datapath.sv */
module pdll_datapath import pdll_pkg::*; #(
  parameter int unsigned Capacity = DefaultCapacity
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [2:0]                  func_i,
  input  logic [7:0]                  position_i,
  input  logic signed [31:0]          value_i,
  input  pdll_cmd_t                   cmd_i,
  output pdll_sts_t                   sts_o,
  output logic [$clog2(Capacity):0]   count_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [2:0]                  status_o,
  output logic [6:0]                  position_res_o,
  output logic signed [31:0]          value_res_o,
  output logic [6:0]                  list_length_o,
  output logic                        last_o
);

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = IdxW + 1;

  logic signed [31:0] val_mem [Capacity];
  logic [IdxW-1:0]    nxt_mem [Capacity];
  logic [IdxW-1:0]    prv_mem [Capacity];

  logic [Capacity-1:0] used_q;
  logic [IdxW-1:0]     head_q, tail_q;
  logic [CntW-1:0]     count_q;
  logic [7:0]          pos_q;
  logic signed [31:0]  key_q;
  logic [2:0]          func_q;
  logic [IdxW-1:0]     cur_q;
  logic [CntW-1:0]     walk_q;
  logic signed [31:0]  rd_val_q;
  logic [IdxW-1:0]     rd_nxt_q, rd_prv_q;
  logic [CntW-1:0]     hold_pos_q;
  logic signed [31:0]  hold_val_q;
  logic                out_valid_q;
  logic [2:0]          st_q;
  logic [6:0]          pres_q, len_q;
  logic signed [31:0]  vres_q;
  logic                last_q;
  logic [IdxW-1:0]     free_idx;

  always_comb begin
    free_idx = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (!used_q[i]) free_idx = IdxW'(i);
    end
  end

  // Node memory: one read port (registered) and writes of the value and link fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_val_q <= val_mem[cur_q];
      rd_nxt_q <= nxt_mem[cur_q];
      rd_prv_q <= prv_mem[cur_q];
    end
    if (cmd_i.link_ins) begin
      val_mem[free_idx] <= key_q;
      if (count_q == '0) begin
      end else if (pos_q == 8'd1) begin
        nxt_mem[free_idx] <= head_q;
        prv_mem[head_q]   <= free_idx;
      end else if (CntW'(pos_q) == count_q + 1'b1) begin
        prv_mem[free_idx] <= tail_q;
        nxt_mem[tail_q]   <= free_idx;
      end else begin
        // cur_q holds the node at pos; rd_prv_q its predecessor.
        nxt_mem[rd_prv_q] <= free_idx;
        prv_mem[free_idx] <= rd_prv_q;
        nxt_mem[free_idx] <= cur_q;
        prv_mem[cur_q]    <= free_idx;
      end
    end
    if (cmd_i.link_del && count_q > CntW'(1) && pos_q != 8'd1 &&
        CntW'(pos_q) != count_q) begin
      nxt_mem[rd_prv_q] <= rd_nxt_q;
      prv_mem[rd_nxt_q] <= rd_prv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.link_ins) begin
        used_q[free_idx] <= 1'b1;
        count_q <= count_q + 1'b1;
        if (count_q == '0) begin
          head_q <= free_idx;
          tail_q <= free_idx;
        end else if (pos_q == 8'd1) begin
          head_q <= free_idx;
        end else if (CntW'(pos_q) == count_q + 1'b1) begin
          tail_q <= free_idx;
        end
      end
      if (cmd_i.link_del) begin
        used_q[cur_q] <= 1'b0;
        count_q <= count_q - 1'b1;
        if (count_q == CntW'(1)) begin
          head_q <= '0;
          tail_q <= '0;
        end else if (pos_q == 8'd1) begin
          head_q <= rd_nxt_q;
        end else if (CntW'(pos_q) == count_q) begin
          tail_q <= rd_prv_q;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      pos_q  <= position_i;
      key_q  <= value_i;
      cur_q  <= cmd_i.start_rev ? tail_q : head_q;
      walk_q <= cmd_i.start_rev ? count_q : CntW'(1);
    end else if (cmd_i.step_fwd) begin
      cur_q  <= rd_nxt_q;
      walk_q <= walk_q + 1'b1;
    end else if (cmd_i.step_rev) begin
      cur_q  <= rd_prv_q;
      walk_q <= walk_q - 1'b1;
    end
    if (cmd_i.stash) begin
      hold_pos_q <= walk_q;
      hold_val_q <= rd_val_q;
    end
    if (cmd_i.emit) begin
      st_q   <= cmd_i.emit_st;
      last_q <= cmd_i.emit_last;
      // The length register reflects count after this cycle's update.
      len_q  <= 7'(cmd_i.link_ins ? count_q + 1'b1 :
                   cmd_i.link_del ? count_q - 1'b1 : count_q);
      if (cmd_i.emit_st != StOk) begin
        pres_q <= '0;
        vres_q <= '0;
      end else if (cmd_i.emit_held) begin
        pres_q <= 7'(hold_pos_q);
        vres_q <= hold_val_q;
      end else if (cmd_i.emit_elem) begin
        pres_q <= 7'(walk_q);
        vres_q <= rd_val_q;
      end else begin
        pres_q <= 7'(pos_q);
        vres_q <= (func_q == FuncDelete) ? rd_val_q : 32'sd0;
      end
    end
  end

  assign sts_o.match     = (rd_val_q == key_q);
  assign sts_o.walk_done = (func_q == FuncReadRev) ? (walk_q == CntW'(1)) :
                           (func_q == FuncReadFwd || func_q == FuncSearch) ?
                           (walk_q == count_q) : (CntW'(pos_q) == walk_q);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign count_o         = count_q;

  assign out_valid_o    = out_valid_q;
  assign status_o       = st_q;
  assign position_res_o = pres_q;
  assign value_res_o    = vres_q;
  assign list_length_o  = len_q;
  assign last_o         = last_q;

endmodule

/* rtl/core/pdll_ctrl.sv */
module pdll_ctrl import pdll_pkg::*; #(
  parameter int unsigned Capacity = DefaultCapacity
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                func_i,
  input  logic [7:0]                position_i,
  input  logic [$clog2(Capacity):0] count_i,
  input  pdll_sts_t                 sts_i,
  output pdll_cmd_t                 cmd_o
);

  localparam int unsigned CntW = $clog2(Capacity) + 1;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRead  = 3'd1; // read issued, data next cycle
  localparam logic [2:0] SEval  = 3'd2; // node data valid
  localparam logic [2:0] SFinal = 3'd3; // search over, parked hit or not found

  logic [2:0] state_q, state_d;
  logic [2:0] func_q, func_d;
  logic       hit_q, hit_d;
  logic       out_free;
  logic       pos_ok_ins, pos_ok_del;

  assign out_free   = !sts_i.out_busy;
  assign pos_ok_ins = position_i != 8'd0 && {1'b0, position_i} <= 9'(count_i) + 9'd1;
  assign pos_ok_del = position_i != 8'd0 && {1'b0, position_i} <= 9'(count_i);

  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    hit_d      = hit_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          func_d    = func_i;
          hit_d     = 1'b0;
          cmd_o.load = 1'b1;
          cmd_o.start_rev = (func_i == FuncReadRev);
          cmd_o.emit_last = 1'b1;
          priority if (func_i == FuncInsert) begin
            if (count_i >= CntW'(Capacity)) begin
              cmd_o.emit = 1'b1; cmd_o.emit_st = StFull;
            end else if (!pos_ok_ins) begin
              cmd_o.emit = 1'b1; cmd_o.emit_st = StRange;
            end else begin
              state_d = SRead;
            end
          end else if (func_i == FuncDelete) begin
            if (count_i == '0) begin
              cmd_o.emit = 1'b1; cmd_o.emit_st = StEmpty;
            end else if (!pos_ok_del) begin
              cmd_o.emit = 1'b1; cmd_o.emit_st = StRange;
            end else begin
              state_d = SRead;
            end
          end else if (func_i == FuncSearch) begin
            if (count_i == '0) begin
              cmd_o.emit = 1'b1; cmd_o.emit_st = StNotFound;
            end else begin
              state_d = SRead;
            end
          end else if (func_i == FuncReadFwd || func_i == FuncReadRev) begin
            if (count_i == '0) begin
              cmd_o.emit = 1'b1; cmd_o.emit_st = StEmpty;
            end else begin
              state_d = SRead;
            end
          end else begin
            // Unused codes: dropped without a result.
          end
        end
      end
      SRead: begin
        cmd_o.rd = 1'b1;
        state_d  = SEval;
      end
      SEval: begin
        if (func_q == FuncInsert || func_q == FuncDelete) begin
          if (!sts_i.walk_done) begin
            cmd_o.step_fwd = 1'b1;
            state_d = SRead;
          end else if (out_free) begin
            cmd_o.link_ins  = (func_q == FuncInsert);
            cmd_o.link_del  = (func_q == FuncDelete);
            cmd_o.emit      = 1'b1;
            cmd_o.emit_st   = StOk;
            cmd_o.emit_last = 1'b1;
            state_d = SIdle;
          end
        end else if (func_q == FuncSearch) begin
          // A hit is parked until the next hit or the end of the walk shows
          // whether it is the final result of the request.
          if (sts_i.match && hit_q) begin
            if (out_free) begin
              cmd_o.emit = 1'b1; cmd_o.emit_st = StOk; cmd_o.emit_held = 1'b1;
              cmd_o.stash = 1'b1;
              if (sts_i.walk_done) begin
                state_d = SFinal;
              end else begin
                cmd_o.step_fwd = 1'b1;
                state_d = SRead;
              end
            end
          end else if (sts_i.match) begin
            hit_d = 1'b1;
            cmd_o.stash = 1'b1;
            if (sts_i.walk_done) begin
              state_d = SFinal;
            end else begin
              cmd_o.step_fwd = 1'b1;
              state_d = SRead;
            end
          end else if (sts_i.walk_done) begin
            state_d = SFinal;
          end else begin
            cmd_o.step_fwd = 1'b1;
            state_d = SRead;
          end
        end else begin
          if (out_free) begin
            cmd_o.emit = 1'b1; cmd_o.emit_st = StOk; cmd_o.emit_elem = 1'b1;
            cmd_o.emit_last = sts_i.walk_done;
            if (sts_i.walk_done) begin
              state_d = SIdle;
            end else begin
              cmd_o.step_fwd = (func_q == FuncReadFwd);
              cmd_o.step_rev = (func_q == FuncReadRev);
              state_d = SRead;
            end
          end
        end
      end
      SFinal: begin
        if (out_free) begin
          cmd_o.emit = 1'b1; cmd_o.emit_last = 1'b1;
          if (hit_q) begin
            cmd_o.emit_st = StOk; cmd_o.emit_held = 1'b1;
          end else begin
            cmd_o.emit_st = StNotFound;
          end
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      func_q  <= FuncInsert;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      func_q  <= func_d;
      hit_q   <= hit_d;
    end
  end

endmodule

/* rtl/core/positional_doubly_linked_list_unit.sv */
// Bounded doubly linked list of signed 32-bit values in a pool of Capacity
// nodes. A request on the input channel (in_valid_i/in_ready_o) carries
// func_i, position_i and value_i; results leave on the output channel
// (out_valid_o/out_ready_i), last_o marking the final result of a request.
// Insert and delete give one result, search one per matching element or a
// single not-found result, and the read-outs one result per element. A
// search hit is held back until the next hit or the end of the walk shows
// whether it carries last_o.
// Every node visit is a registered memory read (SRead) followed by an
// evaluation (SEval). A failed or unused request ends in the idle state;
// an insert or delete walks up to position p, a read-out visits all n
// elements, and a search visits all n elements and then passes SFinal.
// Requests are taken one at a time; a new one is accepted only in the idle
// state with the output register free or being emptied in that cycle.
// Reset empties the list at once (in-use bits, head, tail and count) and
// drops any pending result. A stalled receiver holds the result register,
// and a walk pauses only where it must emit a result, until that is taken.
module positional_doubly_linked_list_unit import pdll_pkg::*; #(
  parameter int unsigned Capacity = DefaultCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         func_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [6:0]         position_res_o,
  output logic signed [31:0] value_res_o,
  output logic [6:0]         list_length_o,
  output logic               last_o
);

  pdll_cmd_t                 cmd;
  pdll_sts_t                 sts;
  logic [$clog2(Capacity):0] count;

  pdll_ctrl #(.Capacity(Capacity)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .position_i,
    .count_i(count), .sts_i(sts), .cmd_o(cmd)
  );

  pdll_datapath #(.Capacity(Capacity)) u_dp (
    .clk_i, .rst_ni, .func_i, .position_i, .value_i,
    .cmd_i(cmd), .sts_o(sts), .count_o(count), .out_ready_i,
    .out_valid_o, .status_o, .position_res_o, .value_res_o,
    .list_length_o, .last_o
  );

`ifndef SYNTH
  // A request is only taken while no result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(out_valid_o && !out_ready_i))
    else $error("request taken while result stalled");
  // The list never grows past its pool.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    list_length_o <= 7'(Capacity) || !out_valid_o)
    else $error("length above capacity");
  // Failed operations report no position and carry last_o.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StOk) |-> (position_res_o == 7'd0 && last_o))
    else $error("bad failure result");
`endif

endmodule
